[hw/rtl/sfd_pkg.sv]
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types, register indexes and the byte-wide CRC-8 step for the
// sync-framed packet deframer.
// ----------------------------------------------------------------------------
package sfd_pkg;

    localparam int BYTE_W = 8;
    localparam int CFG_INDEX_W = 8;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SYNC_FIRST  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SYNC_SECOND = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CRC_POLY    = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_PAYLOAD = 8'd3;

    // register reset values
    localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'hAA;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h55;
    localparam logic [BYTE_W-1:0] CRC_POLY_RST    = 8'h07;
    localparam logic [BYTE_W-1:0] MAX_PAYLOAD_RST = 8'd64;

    // result kinds
    localparam logic KIND_PAYLOAD   = 1'b0;
    localparam logic KIND_FRAME_END = 1'b1;

    // parser phases, one-hot
    typedef enum logic [5:0] {
        PH_SYNC1   = 6'b000001,
        PH_SYNC2   = 6'b000010,
        PH_CMD     = 6'b000100,
        PH_LEN     = 6'b001000,
        PH_PAYLOAD = 6'b010000,
        PH_CRC     = 6'b100000
    } phase_t;

    // configuration seen by the parser
    typedef struct packed {
        logic [BYTE_W-1:0] sync_first;
        logic [BYTE_W-1:0] sync_second;
        logic [BYTE_W-1:0] crc_polynomial;
        logic [BYTE_W-1:0] max_payload;
    } cfg_t;

    // one result item plus its valid flag
    typedef struct packed {
        logic              valid;
        logic              kind;
        logic [BYTE_W-1:0] command;
        logic [BYTE_W-1:0] length;
        logic [BYTE_W-1:0] position;
        logic [BYTE_W-1:0] data_byte;
        logic              crc_good;
    } result_t;

    // one byte through an MSB-first CRC-8, no reflection
    function automatic logic [BYTE_W-1:0] crc8_byte(
        input logic [BYTE_W-1:0] crc,
        input logic [BYTE_W-1:0] data,
        input logic [BYTE_W-1:0] poly
    );
        logic [BYTE_W-1:0] v;
        v = crc ^ data;
        for (int i = 0; i < BYTE_W; i++)
        begin
            if (v[BYTE_W-1])
                v = {v[BYTE_W-2:0], 1'b0} ^ poly;
            else
                v = {v[BYTE_W-2:0], 1'b0};
        end
        return v;
    endfunction

endpackage

[hw/rtl/sfd_cfg_regs.sv]
// ----------------------------------------------------------------------------
// sfd_cfg_regs
// Write-only configuration registers; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module sfd_cfg_regs
    import sfd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]      cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // decode the write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_SYNC_FIRST:  cfg_next.sync_first     = cfg_data;
                REG_SYNC_SECOND: cfg_next.sync_second    = cfg_data;
                REG_CRC_POLY:    cfg_next.crc_polynomial = cfg_data;
                REG_MAX_PAYLOAD: cfg_next.max_payload    = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_first     <= SYNC_FIRST_RST;
            cfg_reg.sync_second    <= SYNC_SECOND_RST;
            cfg_reg.crc_polynomial <= CRC_POLY_RST;
            cfg_reg.max_payload    <= MAX_PAYLOAD_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[hw/rtl/sfd_parser.sv]
// ----------------------------------------------------------------------------
// sfd_parser
// Frame parser: sync hunt, header, payload and CRC check. Takes one byte
// per cycle when step is high and forms at most one result for it.
// ----------------------------------------------------------------------------
module sfd_parser
    import sfd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [BYTE_W-1:0] rx_byte,
    input  cfg_t              cfg,
    output result_t           result
);

    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] command_reg, command_next;
    logic [BYTE_W-1:0] length_reg, length_next;
    logic [BYTE_W-1:0] index_reg, index_next;
    logic [BYTE_W-1:0] crc_reg, crc_next;
    logic [BYTE_W-1:0] crc_in;
    logic [BYTE_W-1:0] crc_stepped;
    logic [BYTE_W-1:0] index_inc;

    // one shared crc step; the command byte restarts from zero
    assign crc_in      = (phase_reg == PH_CMD) ? '0 : crc_reg;
    assign crc_stepped = crc8_byte(crc_in, rx_byte, cfg.crc_polynomial);
    assign index_inc   = index_reg + 8'd1;

    // next state and result
    always_comb
    begin
        phase_next   = phase_reg;
        command_next = command_reg;
        length_next  = length_reg;
        index_next   = index_reg;
        crc_next     = crc_reg;
        result       = '0;
        result.command = command_reg;

        case (phase_reg)
            PH_SYNC2:
            begin
                if (rx_byte == cfg.sync_second)
                    phase_next = PH_CMD;
                else if (rx_byte == cfg.sync_first)
                    phase_next = PH_SYNC2;
                else
                    phase_next = PH_SYNC1;
            end
            PH_CMD:
            begin
                command_next = rx_byte;
                crc_next     = crc_stepped;
                phase_next   = PH_LEN;
            end
            PH_LEN:
            begin
                length_next = rx_byte;
                index_next  = '0;
                crc_next    = crc_stepped;
                if (rx_byte > cfg.max_payload)
                    phase_next = PH_SYNC1;
                else if (rx_byte == '0)
                    phase_next = PH_CRC;
                else
                    phase_next = PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                result.valid     = 1'b1;
                result.kind      = KIND_PAYLOAD;
                result.length    = length_reg;
                result.position  = index_reg;
                result.data_byte = rx_byte;
                crc_next         = crc_stepped;
                index_next       = index_inc;
                if (index_inc >= length_reg)
                    phase_next = PH_CRC;
            end
            PH_CRC:
            begin
                result.valid = 1'b1;
                result.kind  = KIND_FRAME_END;
                if (crc_reg == rx_byte)
                begin
                    result.length   = length_reg;
                    result.crc_good = 1'b1;
                end
                phase_next = PH_SYNC1;
            end
            default:
            begin
                // hunting for the first sync byte
                if (rx_byte == cfg.sync_first)
                    phase_next = PH_SYNC2;
                else
                    phase_next = PH_SYNC1;
            end
        endcase

        if (!step)
            result.valid = 1'b0;
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_SYNC1;
            command_reg <= '0;
            length_reg  <= '0;
            index_reg   <= '0;
            crc_reg     <= '0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            command_reg <= command_next;
            length_reg  <= length_next;
            index_reg   <= index_next;
            crc_reg     <= crc_next;
        end
    end

endmodule

[hw/rtl/sync_framed_packet_deframer_crc8.sv]
// ----------------------------------------------------------------------------
// sync_framed_packet_deframer_crc8
// Byte-serial deframer for sync/command/length/payload/CRC-8 frames.
//
// Input channel: rx_byte with in_valid/in_ready, one received byte per item.
// Output channel: out_valid/out_ready with kind, command, length, position,
// data_byte and crc_good. Each payload byte gives one item (kind 0); the
// CRC byte gives one frame-end item (kind 1) with the verdict, and length
// zero when the CRC does not match. Sync, header and oversized-length bytes
// give no item.
// Path: an accepted byte waits in the input register until the output
// register can take its result; the parser then steps on it and the result
// is held in the output register until taken.
// Throughput: one byte per cycle while out_ready stays high, set by the
// combinational CRC-8 step and parser update between the two registers.
// Configuration: cfg_write/cfg_index/cfg_data write one register per cycle;
// index 0 sync_first, 1 sync_second, 2 crc_polynomial, 3 max_payload.
// Reset: registers return to 0xAA, 0x55, 0x07, 64; the parser hunts for
// the first sync byte and both pipeline registers are empty.
// Stall: while out_ready is low a held result blocks the parser; the input
// register, if empty, still takes one more byte, after which in_ready drops.
// ----------------------------------------------------------------------------
module sync_framed_packet_deframer_crc8
    import sfd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]      cfg_data,
    // input channel
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [BYTE_W-1:0]      rx_byte,
    // output channel
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   kind,
    output logic [BYTE_W-1:0]      command,
    output logic [BYTE_W-1:0]      length,
    output logic [BYTE_W-1:0]      position,
    output logic [BYTE_W-1:0]      data_byte,
    output logic                   crc_good
);

    cfg_t              cfg;
    result_t           result;
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg;
    logic              advance;

    // configuration registers
    sfd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // parse the held byte when the output register can take its result
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    sfd_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .rx_byte (in_byte_reg),
        .cfg     (cfg),
        .result  (result)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_byte_reg <= rx_byte;
    end

    // output register
    always_comb
    begin
        if (advance)
            out_valid_next = result.valid;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && result.valid)
            out_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign kind      = out_reg.kind;
    assign command   = out_reg.command;
    assign length    = out_reg.length;
    assign position  = out_reg.position;
    assign data_byte = out_reg.data_byte;
    assign crc_good  = out_reg.crc_good;

endmodule

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sync-framed packet deframer with CRC-8.
//
// A queue of received bytes feeds a valid/ready driver. At each accepted
// byte, a frame parser in the bench works out the payload and frame-end
// items it should cause. A monitor compares every output item against
// them in order. A directed opening covers the default registers, repeated
// sync, zero length, oversized length, a bad CRC and a polynomial change
// in the middle of a frame. Random phases then cycle the registers through
// extreme and random settings. Both sides stall at random, and the receiver
// holds off once for a long stretch.
// ----------------------------------------------------------------------------
module testbench
    import sfd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES     = 200000;
    localparam int SETTLE_CYCLES    = 4;
    localparam int LONG_HOLD_CYCLES = 80;

    // register indexes beyond the map, written to check they are ignored
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LOW = 8'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_TOP = 8'hFF;

    // one expected output item
    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] command;
        logic [BYTE_W-1:0] length;
        logic [BYTE_W-1:0] position;
        logic [BYTE_W-1:0] data_byte;
        logic              crc_good;
    } frame_item_t;

    logic              clk;
    logic              rst_n      = 1'b0;
    logic              cfg_write  = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [BYTE_W-1:0] cfg_data   = '0;
    logic              in_valid   = 1'b0;
    logic              in_ready;
    logic [BYTE_W-1:0] rx_byte    = '0;
    logic              out_valid;
    logic              out_ready  = 1'b0;
    logic              kind;
    logic [BYTE_W-1:0] command;
    logic [BYTE_W-1:0] length;
    logic [BYTE_W-1:0] position;
    logic [BYTE_W-1:0] data_byte;
    logic              crc_good;

    // bench copy of the registers
    logic [BYTE_W-1:0] cfg_sync_first  = SYNC_FIRST_RST;
    logic [BYTE_W-1:0] cfg_sync_second = SYNC_SECOND_RST;
    logic [BYTE_W-1:0] cfg_crc_poly    = CRC_POLY_RST;
    logic [BYTE_W-1:0] cfg_max_payload = MAX_PAYLOAD_RST;

    // bench copy of the parser state
    phase_t            parse_state   = PH_SYNC1;
    logic [BYTE_W-1:0] cur_command   = '0;
    logic [BYTE_W-1:0] cur_length    = '0;
    logic [BYTE_W-1:0] payload_index = '0;
    logic [BYTE_W-1:0] crc_acc       = '0;

    logic [BYTE_W-1:0] pending_bytes[$];
    frame_item_t       expected_items[$];

    int  queued_bytes   = 0;
    int  mismatch_count = 0;
    int  cycle_count    = 0;
    int  send_gap       = 0;
    int  ready_gap      = 0;
    int  hold_count     = 0;
    bit  quiet          = 1'b0;
    bit  hold_request   = 1'b0;
    bit  rx_long_hold   = 1'b0;

    sync_framed_packet_deframer_crc8 dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .command   (command),
        .length    (length),
        .position  (position),
        .data_byte (data_byte),
        .crc_good  (crc_good)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // msb-first crc-8 over one byte, top bit of the polynomial implied
    function automatic logic [BYTE_W-1:0] crc_next(
        input logic [BYTE_W-1:0] crc,
        input logic [BYTE_W-1:0] b,
        input logic [BYTE_W-1:0] poly
    );
        logic [BYTE_W-1:0] acc;
        acc = crc ^ b;
        repeat (BYTE_W)
            acc = (acc << 1) ^ (acc[BYTE_W-1] ? poly : 8'h00);
        return acc;
    endfunction

    // advance the frame parser by one byte and record any output item
    task automatic deframe_byte(input logic [BYTE_W-1:0] b);
        frame_item_t res;
        case (parse_state)
            PH_SYNC2:
            begin
                if (b == cfg_sync_second)
                    parse_state = PH_CMD;
                else if (b == cfg_sync_first)
                    parse_state = PH_SYNC2;
                else
                    parse_state = PH_SYNC1;
            end
            PH_CMD:
            begin
                cur_command = b;
                crc_acc     = crc_next(8'h00, b, cfg_crc_poly);
                parse_state = PH_LEN;
            end
            PH_LEN:
            begin
                cur_length    = b;
                payload_index = '0;
                crc_acc       = crc_next(crc_acc, b, cfg_crc_poly);
                if (b > cfg_max_payload)
                    parse_state = PH_SYNC1;
                else if (b == 8'd0)
                    parse_state = PH_CRC;
                else
                    parse_state = PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                res = '{kind: KIND_PAYLOAD, command: cur_command, length: cur_length,
                        position: payload_index, data_byte: b, crc_good: 1'b0};
                expected_items.push_back(res);
                crc_acc       = crc_next(crc_acc, b, cfg_crc_poly);
                payload_index = payload_index + 8'd1;
                if (payload_index >= cur_length)
                    parse_state = PH_CRC;
            end
            PH_CRC:
            begin
                // a bad crc reports length zero
                res = '{kind: KIND_FRAME_END, command: cur_command,
                        length: (crc_acc == b) ? cur_length : 8'd0,
                        position: 8'd0, data_byte: 8'd0, crc_good: (crc_acc == b)};
                expected_items.push_back(res);
                parse_state = PH_SYNC1;
            end
            default:
            begin
                if (b == cfg_sync_first)
                    parse_state = PH_SYNC2;
                else
                    parse_state = PH_SYNC1;
            end
        endcase
    endtask

    // input driver: holds each item until taken, random gaps between items
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                deframe_byte(rx_byte);
            if (in_valid && !in_ready)
                in_valid <= 1'b1;
            else if (send_gap != 0)
            begin
                in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (pending_bytes.size() != 0)
            begin
                in_valid <= 1'b1;
                rx_byte  <= pending_bytes.pop_front();
                if (!quiet && $urandom_range(0, 7) == 0)
                    send_gap <= $urandom_range(1, 3);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // one field of an output item against its expectation
    task automatic check_field(
        input string             name,
        input logic [BYTE_W-1:0] want,
        input logic [BYTE_W-1:0] got
    );
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // output monitor and ready generator
    always @(posedge clk)
    begin : output_monitor
        frame_item_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            ready_gap <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_items.size() == 0)
                begin
                    $display("%0t ns: unexpected item, expected none, actual kind %0d data %0h",
                             $time, kind, data_byte);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_items.pop_front();
                    check_field("kind", 8'(want.kind), 8'(kind));
                    check_field("command", want.command, command);
                    check_field("length", want.length, length);
                    check_field("position", want.position, position);
                    check_field("data_byte", want.data_byte, data_byte);
                    check_field("crc_good", 8'(want.crc_good), 8'(crc_good));
                end
            end
            if (rx_long_hold)
                out_ready <= 1'b0;
            else if (ready_gap != 0)
            begin
                out_ready <= 1'b0;
                ready_gap <= ready_gap - 1;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!quiet && $urandom_range(0, 7) == 0)
                    ready_gap <= $urandom_range(1, 3);
            end
        end
    end

    // long receiver hold-off, started by a one-cycle request
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rx_long_hold <= 1'b0;
            hold_count   <= 0;
        end
        else if (rx_long_hold)
        begin
            if (hold_count == LONG_HOLD_CYCLES - 1)
                rx_long_hold <= 1'b0;
            hold_count <= hold_count + 1;
        end
        else if (hold_request)
        begin
            rx_long_hold <= 1'b1;
            hold_count   <= 0;
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    task automatic push_byte(input logic [BYTE_W-1:0] b);
        pending_bytes.push_back(b);
        queued_bytes++;
    endtask

    // complete frame with the current sync bytes and polynomial
    task automatic push_frame(
        input logic [BYTE_W-1:0] cmd,
        input logic [BYTE_W-1:0] len,
        input bit                spoil_crc
    );
        logic [BYTE_W-1:0] crc;
        logic [BYTE_W-1:0] b;
        push_byte(cfg_sync_first);
        push_byte(cfg_sync_second);
        push_byte(cmd);
        push_byte(len);
        crc = crc_next(8'h00, cmd, cfg_crc_poly);
        crc = crc_next(crc, len, cfg_crc_poly);
        for (int i = 0; i < len; i++)
        begin
            b = 8'($urandom);
            push_byte(b);
            crc = crc_next(crc, b, cfg_crc_poly);
        end
        if (spoil_crc)
            crc = crc ^ 8'($urandom_range(1, 255));
        push_byte(crc);
    endtask

    // mostly short payloads, now and then anything up to the maximum
    function automatic logic [BYTE_W-1:0] pick_length();
        int top;
        top = cfg_max_payload;
        if ($urandom_range(0, 19) != 0 && top > 8)
            top = 8;
        return 8'($urandom_range(0, top));
    endfunction

    // well-formed frames for the most part, the rest broken or noise
    task automatic push_random_sequence();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            push_frame(8'($urandom), pick_length(), 1'b0);
        else if (pick < 80)
            push_frame(8'($urandom), pick_length(), 1'b1);
        else if (pick < 88 && cfg_max_payload != 8'hFF)
        begin
            // oversized length drops the frame
            push_byte(cfg_sync_first);
            push_byte(cfg_sync_second);
            push_byte(8'($urandom));
            push_byte(8'($urandom_range(cfg_max_payload + 1, 255)));
        end
        else if (pick < 94)
        begin
            repeat ($urandom_range(1, 3))
                push_byte(cfg_sync_first);
            push_frame(8'($urandom), pick_length(), 1'b0);
        end
        else
        begin
            repeat ($urandom_range(1, 4))
                push_byte(8'($urandom));
        end
    endtask

    task automatic push_random(input int count);
        int stop_at;
        stop_at = queued_bytes + count;
        while (queued_bytes < stop_at)
            push_random_sequence();
    endtask

    // wait until every item is taken and every result seen, then settle
    task automatic wait_idle();
        while (pending_bytes.size() != 0 || in_valid || expected_items.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(
        input logic [CFG_INDEX_W-1:0] idx,
        input logic [BYTE_W-1:0]      val
    );
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_SYNC_FIRST:  cfg_sync_first  = val;
            REG_SYNC_SECOND: cfg_sync_second = val;
            REG_CRC_POLY:    cfg_crc_poly    = val;
            REG_MAX_PAYLOAD: cfg_max_payload = val;
            default: ;
        endcase
    endtask

    task automatic set_config(
        input logic [BYTE_W-1:0] sync_a,
        input logic [BYTE_W-1:0] sync_b,
        input logic [BYTE_W-1:0] poly,
        input logic [BYTE_W-1:0] max_len
    );
        write_reg(REG_SYNC_FIRST, sync_a);
        write_reg(REG_SYNC_SECOND, sync_b);
        write_reg(REG_CRC_POLY, poly);
        write_reg(REG_MAX_PAYLOAD, max_len);
        write_reg(REG_UNUSED_TOP, 8'($urandom));
    endtask

    // stimulus sequence
    initial
    begin : stimulus
        logic [BYTE_W-1:0] crc;
        logic [BYTE_W-1:0] b;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset registers, noise, repeated sync, zero length
        push_byte(8'h00);
        push_byte(cfg_sync_first);
        push_frame(8'hFF, 8'd0, 1'b0);
        // two-byte payload with a bad crc
        push_frame(8'h00, 8'd2, 1'b1);
        // oversized length
        push_byte(cfg_sync_first);
        push_byte(cfg_sync_second);
        push_byte(8'h5A);
        push_byte(cfg_max_payload + 8'd1);
        // broken sync goes back to hunting
        push_byte(cfg_sync_first);
        push_byte(8'h12);
        push_frame(8'h81, 8'd1, 1'b0);

        // polynomial changed between header and payload
        push_byte(cfg_sync_first);
        push_byte(cfg_sync_second);
        push_byte(8'hC3);
        push_byte(8'd3);
        wait_idle();
        write_reg(REG_CRC_POLY, 8'h31);
        write_reg(REG_MAX_PAYLOAD, 8'd2);
        write_reg(REG_UNUSED_LOW, 8'h00);
        crc = crc_acc;
        repeat (3)
        begin
            b = 8'($urandom);
            push_byte(b);
            crc = crc_next(crc, b, cfg_crc_poly);
        end
        push_byte(crc);
        wait_idle();

        // extreme sync values, zero polynomial, largest payload limit
        set_config(8'h00, 8'hFF, 8'h00, 8'hFF);
        push_random(200);
        wait_idle();

        // equal sync bytes, all-ones polynomial, zero payload limit
        set_config(8'h3C, 8'h3C, 8'hFF, 8'h00);
        push_random(150);
        wait_idle();

        // random registers, with a long receiver hold-off while bytes keep coming
        set_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom_range(1, 255)));
        push_random(250);
        @(posedge clk);
        hold_request <= 1'b1;
        @(posedge clk);
        hold_request <= 1'b0;
        wait_idle();

        set_config(8'hFF, 8'h00, 8'h07, 8'd64);
        push_random(200);
        wait_idle();

        // final stretch without idling
        set_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom_range(1, 255)));
        quiet = 1'b1;
        push_random(250);
        wait_idle();

        if (mismatch_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/sfd_pkg.sv
hw/rtl/sfd_cfg_regs.sv
hw/rtl/sfd_parser.sv
hw/rtl/sync_framed_packet_deframer_crc8.sv
tb/sv/testbench.sv
